### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, off while reset is high.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication that also holds across reset.
`define ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

### src/hevl_pkg.sv
// Widths, result type and position tables for the variable-length Hamming encoder.
package hevl_pkg;

   localparam int DATA_W        = 64;
   localparam int LEN_W         = 7;
   localparam int CW_W          = 71;
   localparam int CW_LOW_W      = 64;
   localparam int CW_HIGH_W     = CW_W - CW_LOW_W;
   localparam int CHK_W         = 3;
   localparam int NUM_CHECKS    = 7;
   localparam int MAX_DATA_BITS = 64;

   // codeword positions run from 1 upward
   typedef logic [CW_W:1] codeword_type;

   typedef struct packed {
      logic [CW_HIGH_W-1:0] cw_high;
      logic [CW_LOW_W-1:0]  cw_low;
      logic [LEN_W-1:0]     cw_len;
      logic [CHK_W-1:0]     chk;
   } result_type;

   function automatic logic is_pow2(input int p);
      return (p != 0) && ((p & (p - 1)) == 0);
   endfunction

   // position that takes data bit j: the j-th position that is not a power of two
   function automatic int data_pos(input int j);
      int cnt;
      int res;
      cnt = 0;
      res = 0;
      for (int p = 1; p <= CW_W; p++) begin
         if (!is_pow2(p)) begin
            if (cnt == j) res = p;
            cnt++;
         end
      end
      return res;
   endfunction

   // data positions covered by the check bit at position 2^k
   function automatic codeword_type cover_mask(input int k);
      codeword_type mask;
      mask = '0;
      for (int p = 1; p <= CW_W; p++)
         mask[p] = (((p >> k) & 1) != 0) && !is_pow2(p);
      return mask;
   endfunction

   // fewest check bits r with 2^r >= m + r + 1
   function automatic logic [CHK_W-1:0] check_bits(input logic [LEN_W-1:0] m);
      logic [CHK_W-1:0] res;
      logic             done;
      res  = '0;
      done = 1'b0;
      for (int i = 0; i <= NUM_CHECKS; i++) begin
         if (!done && ((1 << i) >= (int'(m) + i + 1))) begin
            res  = CHK_W'(i);
            done = 1'b1;
         end
      end
      return res;
   endfunction

endpackage

### src/hevl_encode.sv
// Combinational codeword builder: data placement and check bit generation.
module hevl_encode (
   input  logic [hevl_pkg::DATA_W-1:0] data_bits,
   input  logic [hevl_pkg::LEN_W-1:0]  data_length,
   input  logic                        odd_parity,
   output hevl_pkg::result_type        result
);

   logic [hevl_pkg::LEN_W-1:0] m;
   logic [hevl_pkg::CHK_W-1:0] r;
   hevl_pkg::codeword_type     cw;

   always_comb begin
      m = (data_length > hevl_pkg::LEN_W'(hevl_pkg::MAX_DATA_BITS)) ?
          hevl_pkg::LEN_W'(hevl_pkg::MAX_DATA_BITS) : data_length;
      r = hevl_pkg::check_bits(m);

      // minimal r puts exactly m data slots below n, so masking by j < m is enough
      cw = '0;
      for (int j = 0; j < hevl_pkg::DATA_W; j++)
         cw[hevl_pkg::data_pos(j)] = data_bits[j] & (hevl_pkg::LEN_W'(j) < m);

      for (int k = 0; k < hevl_pkg::NUM_CHECKS; k++)
         cw[1 << k] = (hevl_pkg::CHK_W'(k) < r) &
                      (odd_parity ^ (^(cw & hevl_pkg::cover_mask(k))));

      result.cw_low  = cw[hevl_pkg::CW_LOW_W:1];
      result.cw_high = cw[hevl_pkg::CW_W:hevl_pkg::CW_LOW_W+1];
      result.cw_len  = m + hevl_pkg::LEN_W'(r);
      result.chk     = r;
   end

endmodule

### src/hamming_encoder_variable_length_unit.sv
// Variable-length Hamming encoder, input register -> encode logic -> result register.
// The encode logic sits between the two registers; rsp_valid is set with the result.
// Throughput: one word per cycle while the result register is not stalled by rsp_stall.
// A word is taken while a result waits, as long as the input register is free.
// Synchronous reset clears both valid flags; the payload registers are not reset.
module hamming_encoder_variable_length_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [hevl_pkg::DATA_W-1:0]    req_data_bits,
   input  logic [hevl_pkg::LEN_W-1:0]     req_data_length,
   input  logic                           req_odd_parity,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [hevl_pkg::CW_LOW_W-1:0]  rsp_codeword_low,
   output logic [hevl_pkg::CW_HIGH_W-1:0] rsp_codeword_high,
   output logic [hevl_pkg::LEN_W-1:0]     rsp_codeword_length,
   output logic [hevl_pkg::CHK_W-1:0]     rsp_check_count
);

   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   logic [hevl_pkg::DATA_W-1:0] data_ff;
   logic [hevl_pkg::LEN_W-1:0]  length_ff;
   logic                        odd_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   hevl_pkg::result_type        result_ff;
   hevl_pkg::result_type        enc_result;
   logic                        out_free;
   logic                        req_take;

   hevl_encode u_encode (
      .data_bits   (data_ff),
      .data_length (length_ff),
      .odd_parity  (odd_ff),
      .result      (enc_result)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      req_stall    = s1_valid_ff && !out_free;
      req_take     = req_valid && !req_stall;
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
      s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         data_ff   <= req_data_bits;
         length_ff <= req_data_length;
         odd_ff    <= req_odd_parity;
      end
      if (out_free && s1_valid_ff) begin
         result_ff <= enc_result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_codeword_low    = result_ff.cw_low;
   assign rsp_codeword_high   = result_ff.cw_high;
   assign rsp_codeword_length = result_ff.cw_len;
   assign rsp_check_count     = result_ff.chk;

endmodule

### src/hevl_checker.sv
// Port-level checks on the encoder, bound to the top level.
`include "assert_macros.svh"

module hevl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [hevl_pkg::CW_LOW_W-1:0]  rsp_codeword_low,
   input logic [hevl_pkg::CW_HIGH_W-1:0] rsp_codeword_high,
   input logic [hevl_pkg::LEN_W-1:0]     rsp_codeword_length,
   input logic [hevl_pkg::CHK_W-1:0]     rsp_check_count
);

   // empty word: no check bits, no length, nothing set
   `ASSERT_IMP(empty_word_zero, clock, reset,
      rsp_valid && (rsp_check_count == '0),
      (rsp_codeword_length == '0) && (rsp_codeword_low == '0) && (rsp_codeword_high == '0))

   // a codeword of up to 64 positions leaves the high field clear
   `ASSERT_IMP(short_word_high_clear, clock, reset,
      rsp_valid && (rsp_codeword_length <= hevl_pkg::LEN_W'(hevl_pkg::CW_LOW_W)),
      rsp_codeword_high == '0)

   // length never exceeds the longest codeword, nor falls below the check count
   `ASSERT_IMP(length_in_range, clock, reset, rsp_valid,
      (rsp_codeword_length <= hevl_pkg::LEN_W'(hevl_pkg::CW_W)) &&
      (rsp_codeword_length >= hevl_pkg::LEN_W'(rsp_check_count)))

   `ASSERT_NXT(stalled_word_holds, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_codeword_low) && $stable(rsp_codeword_high) &&
      $stable(rsp_codeword_length) && $stable(rsp_check_count))

   `ASSERT_NXT_ALWAYS(reset_clears_valid, clock, reset, !rsp_valid)

endmodule

bind hamming_encoder_variable_length_unit hevl_checker u_hevl_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_codeword_low    (rsp_codeword_low),
   .rsp_codeword_high   (rsp_codeword_high),
   .rsp_codeword_length (rsp_codeword_length),
   .rsp_check_count     (rsp_check_count)
);
